### rtl/core/dbdr_pkg.sv
// ---------------------------------------------------------------------------
// Distance-based deceleration request: shared definitions
// Register indexes, reset values and datapath widths for the request unit.
// ---------------------------------------------------------------------------
package dbdr_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_MIN_DISTANCE    = 2'd0;
	localparam logic [1:0] REG_MIN_ACCEL_LIMIT = 2'd1;
	localparam logic [1:0] REG_MAX_ACCEL_LIMIT = 2'd2;

	// field widths
	localparam int SPEED_W = 16;
	localparam int DIST_W  = 27;
	localparam int DECEL_W = 14;
	localparam int ACCEL_W = 16;
	localparam int MAXL_W  = 15;

	// reset values
	localparam logic [DIST_W-1:0]         MIN_DISTANCE_RST    = 27'd1000;
	localparam logic signed [ACCEL_W-1:0] MIN_ACCEL_LIMIT_RST = -16'sd3000;
	localparam logic [MAXL_W-1:0]         MAX_ACCEL_LIMIT_RST = 15'd1000;

	// datapath widths
	localparam int SQ_W   = 31;                 // square of a 16-bit speed
	localparam int DIFF_W = 32;                 // signed difference of squares
	localparam int N_W    = 33;                 // five times the difference
	localparam int PROD_W = DIST_W + DECEL_W;   // distance times decel magnitude
	localparam int DVD_W  = 35;                 // 2n + distance
	localparam int DVS_W  = DIST_W + 1;         // 2 * distance
	localparam int QUO_W  = 18;                 // quotient bits kept, top one saturates
	localparam int CMP_W  = DVS_W + QUO_W;      // width of the shifted divisor compare

endpackage

### rtl/core/distance_based_decel_request_unit.sv
// ---------------------------------------------------------------------------
// Distance-based deceleration request unit
// Forms -5*(ego^2 - target^2)/distance when the distance lies between the
// minimum distance and the braking distance, clamped and rounded; otherwise
// returns the maximum request.
// ---------------------------------------------------------------------------
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  request  | start / busy      | ego_speed, target_speed, distance,
//           |                   | desired_decel
//  result   | done (one cycle)  | accel_request, request_active
//  config   | cfg_we            | cfg_idx, cfg_wdata
//
//  One word enters per cycle; busy is held low. Each result passes through the
//  squares, difference, scaling and compare stages, then a restoring divider
//  (one quotient bit per stage, the top bit flags saturation) and one output
//  register.
//  Reset clears the valid bits and loads the register reset values.
//  The receiver cannot stall, so the pipeline never holds.
//
module distance_based_decel_request_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [dbdr_pkg::SPEED_W-1:0] ego_speed,
	input  logic signed [dbdr_pkg::SPEED_W-1:0] target_speed,
	input  logic [dbdr_pkg::DIST_W-1:0]      distance,
	input  logic signed [dbdr_pkg::DECEL_W-1:0] desired_decel,
	output logic                             done,
	output logic signed [dbdr_pkg::ACCEL_W-1:0] accel_request,
	output logic                             request_active,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_idx,
	input  logic [dbdr_pkg::DIST_W-1:0]      cfg_wdata
);
	import dbdr_pkg::*;

	localparam int NSTG = QUO_W;

	// configuration registers
	logic [DIST_W-1:0]         min_distance_q;
	logic signed [ACCEL_W-1:0] min_accel_limit_q;
	logic [MAXL_W-1:0]         max_accel_limit_q;

	// write configuration words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_distance_q    <= MIN_DISTANCE_RST;
			min_accel_limit_q <= MIN_ACCEL_LIMIT_RST;
			max_accel_limit_q <= MAX_ACCEL_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MIN_DISTANCE:    min_distance_q    <= cfg_wdata;
				REG_MIN_ACCEL_LIMIT: min_accel_limit_q <= cfg_wdata[ACCEL_W-1:0];
				REG_MAX_ACCEL_LIMIT: max_accel_limit_q <= cfg_wdata[MAXL_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: squares, distance product, speed and sign checks
	logic                  vld_s1, go_s1;
	logic [SQ_W-1:0]       ego_sq_s1, tgt_sq_s1;
	logic [PROD_W-1:0]     prod_s1;
	logic [DIST_W-1:0]     dist_s1;
	logic [DECEL_W-1:0]    mag;
	logic signed [2*SPEED_W-1:0] ego_sq_full, tgt_sq_full;

	assign mag         = DECEL_W'(-desired_decel);
	assign ego_sq_full = ego_speed * ego_speed;
	assign tgt_sq_full = target_speed * target_speed;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end

	always_ff @(posedge clk) begin
		go_s1     <= (ego_speed > target_speed) && desired_decel[DECEL_W-1];
		ego_sq_s1 <= ego_sq_full[SQ_W-1:0];
		tgt_sq_s1 <= tgt_sq_full[SQ_W-1:0];
		prod_s1   <= PROD_W'(distance) * PROD_W'(mag);
		dist_s1   <= distance;
	end

	// stage 2: difference of squares, minimum distance check
	logic                     vld_s2, go_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	logic [PROD_W-1:0]        prod_s2;
	logic [DIST_W-1:0]        dist_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		go_s2   <= go_s1 && (dist_s1 > min_distance_q);
		diff_s2 <= $signed({1'b0, ego_sq_s1}) - $signed({1'b0, tgt_sq_s1});
		prod_s2 <= prod_s1;
		dist_s2 <= dist_s1;
	end

	// stage 3: scale the difference by five
	logic              vld_s3, go_s3;
	logic [N_W-1:0]    n_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [DIST_W-1:0] dist_s3;
	logic [N_W-1:0]    diff_u;

	assign diff_u = N_W'(diff_s2[SQ_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		go_s3   <= go_s2 && (diff_s2 > 0);
		n_s3    <= (diff_u << 2) + diff_u;
		prod_s3 <= prod_s2;
		dist_s3 <= dist_s2;
	end

	// stage 4: braking distance compare, form dividend and divisor
	logic              vld_s4, act_s4;
	logic [DVD_W-1:0]  dvd_s4;
	logic [DVS_W-1:0]  dvs_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		act_s4 <= go_s3 && (prod_s3 < PROD_W'(n_s3));
		dvd_s4 <= (DVD_W'(n_s3) << 1) + DVD_W'(dist_s3);
		dvs_s4 <= {dist_s3, 1'b0};
	end

	// divider stages: one restoring step each, most significant bit first
	logic             div_vld_s [0:NSTG];
	logic             div_act_s [0:NSTG];
	logic [DVD_W-1:0] div_rem_s [0:NSTG];
	logic [DVS_W-1:0] div_dvs_s [0:NSTG];
	logic [QUO_W-1:0] div_quo_s [0:NSTG];

	assign div_vld_s[0] = vld_s4;
	assign div_act_s[0] = act_s4;
	assign div_rem_s[0] = dvd_s4;
	assign div_dvs_s[0] = dvs_s4;
	assign div_quo_s[0] = '0;

	for (genvar k = 0; k < NSTG; k++) begin : g_div
		logic [CMP_W-1:0] trial;
		logic [CMP_W-1:0] rem_ext;
		logic             take;

		assign trial   = CMP_W'(div_dvs_s[k]) << (NSTG - 1 - k);
		assign rem_ext = CMP_W'(div_rem_s[k]);
		assign take    = rem_ext >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_vld_s[k+1] <= 1'b0;
			else         div_vld_s[k+1] <= div_vld_s[k];
		end

		always_ff @(posedge clk) begin
			div_act_s[k+1] <= div_act_s[k];
			div_dvs_s[k+1] <= div_dvs_s[k];
			div_quo_s[k+1] <= {div_quo_s[k][QUO_W-2:0], take};
			div_rem_s[k+1] <= take ? DVD_W'(rem_ext - trial) : div_rem_s[k];
		end
	end

	// output stage: negate, clamp to the lower limit, or fall back to maximum
	logic                        sat;
	logic signed [QUO_W-1:0]     neg_req;
	logic signed [QUO_W-1:0]     min_ext;
	logic                        below;
	logic signed [ACCEL_W-1:0]   req_next;

	assign sat     = div_quo_s[NSTG][QUO_W-1];
	assign neg_req = -$signed({1'b0, div_quo_s[NSTG][QUO_W-2:0]});
	assign min_ext = QUO_W'(min_accel_limit_q);
	assign below   = sat || (neg_req < min_ext);

	always_comb begin
		if (!div_act_s[NSTG])
			req_next = $signed({1'b0, max_accel_limit_q});
		else if (below)
			req_next = min_accel_limit_q;
		else
			req_next = neg_req[ACCEL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= div_vld_s[NSTG];
	end

	always_ff @(posedge clk) begin
		accel_request  <= req_next;
		request_active <= div_act_s[NSTG];
	end

endmodule
